[design/cbv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Consensus base voter package
// Symbol codes, vote order and transaction types shared by the voter files.
// ----------------------------------------------------------------------------
package cbv_pkg;

  localparam int unsigned NumSymbols = 6;
  localparam int unsigned CodeW      = 3;
  localparam int unsigned QualW      = 6;
  localparam int unsigned QsumW      = 14;
  localparam int unsigned WcountW    = 8;
  localparam int unsigned TotalW     = 11;

  localparam logic [CodeW-1:0] SYM_A   = 3'd0;
  localparam logic [CodeW-1:0] SYM_C   = 3'd1;
  localparam logic [CodeW-1:0] SYM_G   = 3'd2;
  localparam logic [CodeW-1:0] SYM_T   = 3'd3;
  localparam logic [CodeW-1:0] SYM_N   = 3'd4;
  localparam logic [CodeW-1:0] SYM_GAP = 3'd5;

  localparam logic [QsumW-1:0]   QSUM_MAX   = '1;
  localparam logic [WcountW-1:0] WCOUNT_MAX = '1;
  localparam logic [TotalW-1:0]  TOTAL_MAX  = '1;

  // Earlier entries win ties.
  localparam logic [CodeW-1:0] SCAN_ORDER [NumSymbols] = '{
    SYM_GAP, SYM_C, SYM_G, SYM_A, SYM_T, SYM_N
  };

  typedef struct packed {
    logic [CodeW-1:0] base_code;
    logic [QualW-1:0] quality;
    logic             new_column;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]   consensus;
    logic [WcountW-1:0] winner_count;
    logic [QsumW-1:0]   winner_quality;
    logic [TotalW-1:0]  total_bases;
  } out_item_t;

endpackage

[design/cbv_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Consensus base voter stream interfaces
// Valid/ready channels for base call transactions and vote result transactions.
// ----------------------------------------------------------------------------
interface cbv_in_if;
  logic             valid;
  logic             ready;
  cbv_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbv_out_if;
  logic               valid;
  logic               ready;
  cbv_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/consensus_base_voter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Consensus base voter
// Majority vote over one alignment column, by call counts or quality sums.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one base call per transaction: symbol code, quality and a
//   flag that opens a new column. out_o returns one result per base call:
//   the consensus symbol, its count, its quality sum in quality mode and
//   the number of non-gap calls in the column so far.
//   The quality_mode register is written through cfg_we_i and cfg_wdata_i;
//   the user must write it only while no transaction is in flight, as the
//   block does not enforce this. An accepted call is held in an input
//   register; from it the column counters are updated and the vote is taken
//   by a six-way compare, both in combinational logic, and the counters and
//   the result register load together when the call advances. One call is
//   accepted in every cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds its transaction,
//   the input register fills and then in_i.ready falls; nothing is lost.
//   Reset clears all counts and sums, clears quality_mode and empties both
//   registers.
// ----------------------------------------------------------------------------
module consensus_base_voter #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  cbv_in_if.sink           in_i,
  cbv_out_if.source        out_o
);

  localparam int unsigned NSym   = cbv_pkg::NumSymbols;
  localparam int unsigned QsumW  = cbv_pkg::QsumW;
  localparam int unsigned SumW   = COUNT_BITS + 3;
  localparam int unsigned TotExtW = (SumW > cbv_pkg::TotalW) ? SumW : cbv_pkg::TotalW + 1;
  localparam int unsigned WcExtW  =
    (COUNT_BITS > cbv_pkg::WcountW) ? COUNT_BITS : cbv_pkg::WcountW + 1;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic                   mode_q;
  logic                   s1_valid_q;
  cbv_pkg::in_item_t      s1_item_q;
  logic                   out_valid_q;
  cbv_pkg::out_item_t     out_item_q, out_item_d;
  logic [COUNT_BITS-1:0]  cnt_q [NSym];
  logic [COUNT_BITS-1:0]  cnt_d [NSym];
  logic [QsumW-1:0]       qsum_q [NSym];
  logic [QsumW-1:0]       qsum_d [NSym];
  logic                   advance;

  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  always_comb begin
    logic [COUNT_BITS-1:0] cbase;
    logic [QsumW-1:0]      qbase;
    logic [QsumW:0]        qadd;
    for (int i = 0; i < NSym; i++) begin
      cbase = s1_item_q.new_column ? '0 : cnt_q[i];
      qbase = s1_item_q.new_column ? '0 : qsum_q[i];
      qadd  = {1'b0, qbase} + (QsumW + 1)'(s1_item_q.quality);
      cnt_d[i]  = cbase;
      qsum_d[i] = qbase;
      if (s1_item_q.base_code == cbv_pkg::CodeW'(i)) begin
        if (cbase != CountMax) begin
          cnt_d[i] = cbase + COUNT_BITS'(1);
        end
        if (mode_q) begin
          qsum_d[i] = qadd[QsumW] ? cbv_pkg::QSUM_MAX : qadd[QsumW-1:0];
        end
      end
    end
  end

  always_comb begin
    logic [cbv_pkg::CodeW-1:0] best_sym;
    logic [COUNT_BITS-1:0]     best_cnt;
    logic [QsumW-1:0]          best_qsum;
    logic [COUNT_BITS-1:0]     c;
    logic [QsumW-1:0]          q;
    logic [SumW-1:0]           total;
    logic [TotExtW-1:0]        total_ext;
    logic [WcExtW-1:0]         wc_ext;
    best_sym  = cbv_pkg::SCAN_ORDER[0];
    best_cnt  = cnt_d[cbv_pkg::SYM_GAP];
    best_qsum = qsum_d[cbv_pkg::SYM_GAP];
    for (int i = 1; i < NSym; i++) begin
      c = cnt_d[cbv_pkg::SCAN_ORDER[i]];
      q = qsum_d[cbv_pkg::SCAN_ORDER[i]];
      if (mode_q ? (q > best_qsum) : (c > best_cnt)) begin
        best_sym  = cbv_pkg::SCAN_ORDER[i];
        best_cnt  = c;
        best_qsum = q;
      end
    end
    total = '0;
    for (int i = 0; i < NSym - 1; i++) begin
      total = total + SumW'(cnt_d[i]);
    end
    total_ext = TotExtW'(total);
    wc_ext    = WcExtW'(best_cnt);
    out_item_d.consensus      = best_sym;
    out_item_d.winner_count   = (wc_ext > WcExtW'(cbv_pkg::WCOUNT_MAX)) ?
                                cbv_pkg::WCOUNT_MAX : wc_ext[cbv_pkg::WcountW-1:0];
    out_item_d.winner_quality = mode_q ? best_qsum : '0;
    out_item_d.total_bases    = (total_ext > TotExtW'(cbv_pkg::TOTAL_MAX)) ?
                                cbv_pkg::TOTAL_MAX : total_ext[cbv_pkg::TotalW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NSym; i++) begin
        cnt_q[i]  <= '0;
        qsum_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < NSym; i++) begin
          cnt_q[i]  <= cnt_d[i];
          qsum_q[i] <= qsum_d[i];
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q <= in_i.data;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

`ifndef SYNTHESIS
  a_advance_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("Result register not loaded after a transaction advanced.");

  a_count_mode_no_quality: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !mode_q) |-> (out_item_q.winner_quality == '0))
    else $error("Quality sum reported in count mode.");

  a_winner_within_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.consensus != cbv_pkg::SYM_GAP)) |->
      (11'(out_item_q.winner_count) <= out_item_q.total_bases))
    else $error("Winner count exceeds the total of non-gap calls.");

  a_stage_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("Input accepted while both registers are full and stalled.");
`endif

endmodule
